// ----- src/ckh_pkg.sv -----
// Shared types, codes and constants of the cuckoo hash insert block.
// Used by every module under src; depends on nothing.
package ckh_pkg;

  // Default sizes of the storage.
  localparam int ITEM_DEPTH_DEF  = 1024;
  localparam int BIN_DEPTH_DEF   = 2048;
  localparam int STASH_DEPTH_DEF = 16;

  // Register reset values.
  localparam logic [11:0] BIN_COUNT_RST = 12'd1229;
  localparam logic [11:0] MAX_KICKS_RST = 12'd1024;

  // Configuration register indexes.
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  REG_BIN_COUNT = 2'd0;
  localparam logic [1:0]  REG_MAX_KICKS = 2'd1;

  // Request codes.
  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_READ_BIN   = 2'd1;
  localparam logic [1:0] REQ_READ_STASH = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_STASHED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  // Hash choices.
  localparam logic [1:0] CHOICE_0 = 2'd0;
  localparam logic [1:0] CHOICE_1 = 2'd1;
  localparam logic [1:0] CHOICE_2 = 2'd2;

  // Quotient bits resolved per cycle by the modulo unit.
  localparam int MOD_DIGIT = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  item_index;
    logic [63:0] hash_first;
    logic [63:0] hash_second;
    logic [63:0] hash_third;
    logic [10:0] bin_address;
    logic [3:0]  stash_slot;
  } ckh_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] kick_count;
    logic        entry_valid;
    logic [9:0]  entry_item;
    logic [1:0]  entry_choice;
    logic [4:0]  stash_fill;
  } ckh_out_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] choice;
    logic [9:0] item;
  } bin_ent_t;

  typedef struct packed {
    logic [1:0] choice;
    logic [9:0] item;
  } stash_ent_t;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] third;
  } hash_set_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HRD, S_MODST, S_MOD, S_BRD, S_DEC,
    S_RBIN, S_RBCAP, S_RSTASH, S_RSCAP, S_DONE
  } ckh_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic hash_rd;
    logic mod_start;
    logic bin_rd;
    logic place;
    logic swap;
    logic stash_push;
    logic bin_cap;
    logic stash_rd;
    logic stash_cap;
    logic out_load;
  } ckh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic bin_occ;
    logic kick_ok;
  } ckh_stat_t;

  // Choice that an evicted item tries next.
  function automatic logic [1:0] next_choice(input logic [1:0] c);
    logic [1:0] n;
    case (c)
      CHOICE_0: n = CHOICE_1;
      CHOICE_1: n = CHOICE_2;
      default:  n = CHOICE_0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/ckh_mod.sv -----
// Iterative remainder unit: 64-bit dividend modulo a bin count.
// Resolves MOD_DIGIT quotient bits per cycle; uses ckh_pkg.
module ckh_mod #(
  parameter int BCW = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [63:0]    dividend,
  input  logic [BCW-1:0] divisor,
  output logic           done,
  output logic [BCW-1:0] rem
);
  import ckh_pkg::*;

  localparam int STEPS = 64 / MOD_DIGIT;
  localparam int CW    = $clog2(STEPS);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [63:0]    dvd_r, dvd_nxt;
  logic [BCW-1:0] div_r, div_nxt;
  logic [BCW-1:0] rem_r, rem_nxt;

  // One digit of restoring division per cycle.
  always_comb begin
    logic [BCW:0]   t;
    logic [BCW-1:0] r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    r        = rem_r;
    t        = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      for (int k = 0; k < MOD_DIGIT; k++) begin
        t = {r, dvd_r[63-k]};
        if (t >= {1'b0, div_r}) begin
          r = BCW'(t - {1'b0, div_r});
        end else begin
          r = BCW'(t);
        end
      end
      rem_nxt = r;
      dvd_nxt = dvd_r << MOD_DIGIT;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  // A started division runs on in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("modulo unit did not start");

  // Done follows only a running division.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("modulo done without work");

  // The remainder stays below the divisor once done.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r)) else $error("remainder out of range");

endmodule

// ----- src/ckh_ctrl.sv -----
// Controller state machine of the cuckoo hash block.
// Drives the datapath with ckh_cmd_t and reads ckh_stat_t; uses ckh_pkg.
module ckh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_req,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ckh_pkg::ckh_stat_t stat,
  output ckh_pkg::ckh_cmd_t  cmd
);
  import ckh_pkg::*;

  ckh_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_req)
            REQ_INSERT:     state_nxt = S_HRD;
            REQ_READ_BIN:   state_nxt = S_RBIN;
            REQ_READ_STASH: state_nxt = S_RSTASH;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_HRD:    state_nxt = S_MODST;
      S_MODST:  state_nxt = S_MOD;
      S_MOD:    if (stat.mod_done) state_nxt = S_BRD;
      S_BRD:    state_nxt = S_DEC;
      S_DEC: begin
        if (stat.bin_occ && stat.kick_ok) state_nxt = S_HRD;
        else state_nxt = S_DONE;
      end
      S_RBIN:   state_nxt = S_RBCAP;
      S_RBCAP:  state_nxt = S_DONE;
      S_RSTASH: state_nxt = S_RSCAP;
      S_RSCAP:  state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd            = '0;
    cmd.clr_step   = (state_r == S_CLEAR);
    cmd.latch      = (state_r == S_IDLE) && in_valid;
    cmd.hash_rd    = (state_r == S_HRD);
    cmd.mod_start  = (state_r == S_MODST);
    cmd.bin_rd     = (state_r == S_BRD) || (state_r == S_RBIN);
    cmd.place      = (state_r == S_DEC) && !stat.bin_occ;
    cmd.swap       = (state_r == S_DEC) && stat.bin_occ && stat.kick_ok;
    cmd.stash_push = (state_r == S_DEC) && stat.bin_occ && !stat.kick_ok;
    cmd.bin_cap    = (state_r == S_RBCAP);
    cmd.stash_rd   = (state_r == S_RSTASH);
    cmd.stash_cap  = (state_r == S_RSCAP);
    cmd.out_load   = (state_r == S_DONE) && out_free;
  end

  // The result register is full from its load until the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free) else $error("result overwritten");

  // No two of place, swap and stash push are issued in the same cycle.
  a_one_dec: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.place, cmd.swap, cmd.stash_push}))
    else $error("conflicting decisions");

  // A waiting result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result beat withdrawn");

endmodule

// ----- src/ckh_dp.sv -----
// Datapath of the cuckoo hash block: bin, hash and stash memories,
// configuration registers, modulo unit and result register. Uses ckh_pkg, ckh_mod.
module ckh_dp #(
  parameter int ITEM_DEPTH  = ckh_pkg::ITEM_DEPTH_DEF,
  parameter int BIN_DEPTH   = ckh_pkg::BIN_DEPTH_DEF,
  parameter int STASH_DEPTH = ckh_pkg::STASH_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ckh_pkg::ckh_in_t            in_data,
  input  logic                        cfg_valid,
  input  logic [ckh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                 cfg_data,
  input  ckh_pkg::ckh_cmd_t           cmd,
  output ckh_pkg::ckh_stat_t          stat,
  output ckh_pkg::ckh_out_t           out_data
);
  import ckh_pkg::*;

  localparam int IAW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
  localparam int BAW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
  localparam int BCW = $clog2(BIN_DEPTH + 1);
  localparam int SAW = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
  localparam int SUW = $clog2(STASH_DEPTH + 1);

  // Memories.
  bin_ent_t   bin_mem   [BIN_DEPTH];
  hash_set_t  hash_mem  [ITEM_DEPTH];
  stash_ent_t stash_mem [STASH_DEPTH];

  logic [11:0]    bin_count_r, max_kicks_r;
  logic [9:0]     item_r;
  logic [1:0]     choice_r;
  logic [11:0]    kicks_r;
  logic [BCW-1:0] nb_r;
  logic [BAW-1:0] addr_r;
  logic           rd_ok_r;
  logic [3:0]     slot_r;
  logic [1:0]     status_r;
  logic           ent_valid_r;
  logic [9:0]     ent_item_r;
  logic [1:0]     ent_choice_r;
  logic [SUW-1:0] used_r;
  logic [BAW-1:0] clr_cnt_r;
  ckh_out_t       out_data_r;
  bin_ent_t       bin_q_r;
  hash_set_t      hash_q_r;
  stash_ent_t     stash_q_r;

  logic           stash_full;
  logic [BCW-1:0] active_bins;
  logic [IAW-1:0] in_hslot, hslot;
  logic [63:0]    mod_dvd;
  logic           mod_done;
  logic [BCW-1:0] mod_rem;
  logic           bin_we;
  logic [BAW-1:0] bin_wa;
  bin_ent_t       bin_wd;
  logic           slot_ok;

  // Bin count in use: zero counts as one, large values saturate.
  always_comb begin
    if (bin_count_r == 12'd0) begin
      active_bins = BCW'(1);
    end else if (32'(bin_count_r) > BIN_DEPTH) begin
      active_bins = BCW'(BIN_DEPTH);
    end else begin
      active_bins = BCW'(bin_count_r);
    end
  end

  assign in_hslot   = IAW'(32'(in_data.item_index) % ITEM_DEPTH);
  assign hslot      = IAW'(32'(item_r) % ITEM_DEPTH);
  assign stash_full = (32'(used_r) >= STASH_DEPTH);
  assign slot_ok    = (32'(slot_r) < 32'(used_r)) && (32'(slot_r) < STASH_DEPTH);

  // Hash of the current choice feeds the remainder unit.
  always_comb begin
    case (choice_r)
      CHOICE_0: mod_dvd = hash_q_r.first;
      CHOICE_1: mod_dvd = hash_q_r.second;
      default:  mod_dvd = hash_q_r.third;
    endcase
  end

  ckh_mod #(.BCW(BCW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (nb_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Bin write port: clearing sweep, placement or swap.
  always_comb begin
    bin_we = cmd.clr_step || cmd.place || cmd.swap;
    if (cmd.clr_step) begin
      bin_wa = clr_cnt_r;
      bin_wd = '0;
    end else begin
      bin_wa = addr_r;
      bin_wd = '{valid: 1'b1, choice: choice_r, item: item_r};
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (cmd.bin_rd) bin_q_r <= bin_mem[addr_r];
  end

  // Per-item hash memory.
  always_ff @(posedge clk) begin
    if (cmd.latch && (in_data.req_type == REQ_INSERT)) begin
      hash_mem[in_hslot] <= '{first: in_data.hash_first, second: in_data.hash_second,
                              third: in_data.hash_third};
    end
    if (cmd.hash_rd) hash_q_r <= hash_mem[hslot];
  end

  // Stash memory.
  always_ff @(posedge clk) begin
    if (cmd.stash_push && !stash_full) begin
      stash_mem[SAW'(used_r)] <= '{choice: choice_r, item: item_r};
    end
    if (cmd.stash_rd) stash_q_r <= stash_mem[SAW'(slot_r)];
  end

  // Control registers: configuration, clearing count, stash fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= BIN_COUNT_RST;
      max_kicks_r <= MAX_KICKS_RST;
      clr_cnt_r   <= '0;
      used_r      <= '0;
    end else begin
      if (cfg_valid && (cfg_index == REG_BIN_COUNT)) bin_count_r <= cfg_data;
      if (cfg_valid && (cfg_index == REG_MAX_KICKS)) max_kicks_r <= cfg_data;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.stash_push && !stash_full) used_r <= used_r + 1'b1;
    end
  end

  // Item in hand, eviction count and result fields.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r       <= in_data.item_index;
      choice_r     <= CHOICE_0;
      kicks_r      <= '0;
      nb_r         <= active_bins;
      addr_r       <= BAW'(in_data.bin_address);
      rd_ok_r      <= (32'(in_data.bin_address) < BIN_DEPTH);
      slot_r       <= in_data.stash_slot;
      status_r     <= ST_READ;
      ent_valid_r  <= 1'b0;
      ent_item_r   <= '0;
      ent_choice_r <= '0;
    end
    if (mod_done) addr_r <= BAW'(mod_rem);
    if (cmd.place) status_r <= ST_PLACED;
    if (cmd.swap) begin
      item_r   <= bin_q_r.item;
      choice_r <= next_choice(bin_q_r.choice);
      kicks_r  <= kicks_r + 1'b1;
    end
    if (cmd.stash_push) status_r <= stash_full ? ST_DROPPED : ST_STASHED;
    if (cmd.bin_cap && rd_ok_r && bin_q_r.valid) begin
      ent_valid_r  <= 1'b1;
      ent_item_r   <= bin_q_r.item;
      ent_choice_r <= bin_q_r.choice;
    end
    if (cmd.stash_cap && slot_ok) begin
      ent_valid_r  <= 1'b1;
      ent_item_r   <= stash_q_r.item;
      ent_choice_r <= stash_q_r.choice;
    end
    if (cmd.out_load) begin
      out_data_r <= '{status: status_r, kick_count: kicks_r, entry_valid: ent_valid_r,
                      entry_item: ent_item_r, entry_choice: ent_choice_r,
                      stash_fill: 5'(used_r)};
    end
  end

  assign stat.clr_last = (clr_cnt_r == BAW'(BIN_DEPTH - 1));
  assign stat.mod_done = mod_done;
  assign stat.bin_occ  = bin_q_r.valid;
  assign stat.kick_ok  = (kicks_r < max_kicks_r);
  assign out_data      = out_data_r;

  // The stash never holds more entries than it has.
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= STASH_DEPTH) else $error("stash fill overflow");

  // An eviction only happens within the allowed count.
  a_swap_kicks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap |-> (kicks_r < max_kicks_r)) else $error("too many evictions");

  // A pushed item raises the fill by one unless the stash was full.
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.stash_push && !stash_full) |=> (used_r == $past(used_r) + 1'b1))
    else $error("stash fill not advanced");

endmodule

// ----- src/cuckoo_hash_insert_stash.sv -----
// Top level of the cuckoo hash insert block with stash.
// Joins ckh_ctrl and ckh_dp; uses ckh_pkg.
//
// After reset the block sweeps the bin memory clear and accepts no request
// until the sweep is done; configuration writes are taken at any time. A
// read goes from accept through the bin or stash read and the capture to
// the result register. Every step of an insert's eviction chain reads the
// item's stored hash, reduces it modulo the bin count in a remainder unit
// that settles four bits a cycle, then reads the bin memory and places,
// swaps or stashes the item. One request is worked on at a time; a new one
// is accepted while the previous result still waits at the output.
module cuckoo_hash_insert_stash #(
  parameter int ITEM_DEPTH  = ckh_pkg::ITEM_DEPTH_DEF,
  parameter int BIN_DEPTH   = ckh_pkg::BIN_DEPTH_DEF,
  parameter int STASH_DEPTH = ckh_pkg::STASH_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ckh_pkg::ckh_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ckh_pkg::ckh_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data
);
  import ckh_pkg::*;

  ckh_cmd_t  cmd;
  ckh_stat_t stat;

  assign cfg_ready = 1'b1;

  ckh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_data.req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ckh_dp #(
    .ITEM_DEPTH  (ITEM_DEPTH),
    .BIN_DEPTH   (BIN_DEPTH),
    .STASH_DEPTH (STASH_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the cuckoo hash insert block with stash.
// Depends on ckh_pkg and cuckoo_hash_insert_stash under src.
`timescale 1ns / 1ps

module testbench;
  import ckh_pkg::*;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
  localparam int         BIN_SLOTS    = BIN_DEPTH_DEF;
  localparam int         ITEM_SLOTS   = ITEM_DEPTH_DEF;
  localparam int         STASH_SLOTS  = STASH_DEPTH_DEF;
  localparam int         IDLE_LIMIT   = 300000;
  localparam int         SETTLE_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ckh_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ckh_out_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  cuckoo_hash_insert_stash i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the table, the hash memory, the stash and the registers.
  bit          occupied_m [BIN_SLOTS];
  logic [9:0]  owner_m    [BIN_SLOTS];
  logic [1:0]  way_m      [BIN_SLOTS];
  logic [63:0] hash0_m    [ITEM_SLOTS];
  logic [63:0] hash1_m    [ITEM_SLOTS];
  logic [63:0] hash2_m    [ITEM_SLOTS];
  logic [9:0]  stash_item_m   [STASH_SLOTS];
  logic [1:0]  stash_way_m    [STASH_SLOTS];
  int unsigned stash_count_m = 0;
  logic [11:0] bin_count_m = BIN_COUNT_RST;
  logic [11:0] max_kicks_m = MAX_KICKS_RST;

  ckh_in_t  request_queue [$];
  ckh_out_t awaited_results [$];
  int       mismatches = 0;
  int       results_seen = 0;

  // Computes the result of one request and updates the mirror.
  function automatic bit predict_result(input ckh_in_t rq, output ckh_out_t res);
    int unsigned nb, kicks, addr;
    logic [9:0]  it, ev_it;
    logic [1:0]  way, ev_way;
    logic [63:0] hv;
    bit          done;
    res = '0;
    res.status = ST_READ;
    case (rq.req_type)
      REQ_INSERT: begin
        nb = (bin_count_m == 0) ? 1 : (bin_count_m > BIN_SLOTS) ? BIN_SLOTS : bin_count_m;
        it = rq.item_index;
        way = CHOICE_0;
        kicks = 0;
        done = 0;
        hash0_m[it] = rq.hash_first;
        hash1_m[it] = rq.hash_second;
        hash2_m[it] = rq.hash_third;
        while (!done) begin
          case (way)
            CHOICE_0: hv = hash0_m[it];
            CHOICE_1: hv = hash1_m[it];
            default:  hv = hash2_m[it];
          endcase
          addr = hv % nb;
          if (!occupied_m[addr]) begin
            occupied_m[addr] = 1;
            owner_m[addr] = it;
            way_m[addr] = way;
            res.status = ST_PLACED;
            done = 1;
          end else if (kicks < max_kicks_m) begin
            // Evict the occupant; it moves on to its next hash choice.
            ev_it = owner_m[addr];
            ev_way = way_m[addr];
            owner_m[addr] = it;
            way_m[addr] = way;
            it = ev_it;
            way = (ev_way == CHOICE_2) ? CHOICE_0 : ev_way + 2'd1;
            kicks++;
          end else begin
            if (stash_count_m < STASH_SLOTS) begin
              stash_item_m[stash_count_m] = it;
              stash_way_m[stash_count_m] = way;
              stash_count_m++;
              res.status = ST_STASHED;
            end else begin
              res.status = ST_DROPPED;
            end
            done = 1;
          end
        end
        res.kick_count = kicks[11:0];
      end
      REQ_READ_BIN: begin
        if (occupied_m[rq.bin_address]) begin
          res.entry_valid = 1'b1;
          res.entry_item = owner_m[rq.bin_address];
          res.entry_choice = way_m[rq.bin_address];
        end
      end
      REQ_READ_STASH: begin
        if (rq.stash_slot < stash_count_m) begin
          res.entry_valid = 1'b1;
          res.entry_item = stash_item_m[rq.stash_slot];
          res.entry_choice = stash_way_m[rq.stash_slot];
        end
      end
      default: return 0;
    endcase
    res.stash_fill = stash_count_m[4:0];
    return 1;
  endfunction

  function automatic logic [63:0] rand_hash();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Random request; ins_pct sets the share of inserts, bin_span the range of most bin reads.
  function automatic ckh_in_t rand_request(int ins_pct, int bin_span);
    ckh_in_t rq;
    int r;
    rq.item_index = $urandom_range(0, 1023);
    rq.hash_first = rand_hash();
    rq.hash_second = rand_hash();
    rq.hash_third = rand_hash();
    rq.stash_slot = $urandom_range(0, 15);
    rq.bin_address = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(0, bin_span - 1);
    r = $urandom_range(0, 99);
    if (r < ins_pct) rq.req_type = REQ_INSERT;
    else if (r < ins_pct + (100 - ins_pct) * 6 / 10) rq.req_type = REQ_READ_BIN;
    else if (r < 97) rq.req_type = REQ_READ_STASH;
    else rq.req_type = REQ_UNKNOWN;
    return rq;
  endfunction

  function automatic ckh_in_t make_request(logic [1:0] kind, logic [9:0] item,
                                           logic [63:0] h0, logic [63:0] h1,
                                           logic [63:0] h2, logic [10:0] addr,
                                           logic [3:0] slot);
    ckh_in_t rq;
    rq.req_type = kind;
    rq.item_index = item;
    rq.hash_first = h0;
    rq.hash_second = h1;
    rq.hash_third = h2;
    rq.bin_address = addr;
    rq.stash_slot = slot;
    return rq;
  endfunction

  // Gap length: mostly short, some long, and calm stretches with none.
  function automatic int draw_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Request driver.
  int send_gap = 0;
  bit send_calm = 0;
  always @(posedge clk) begin
    ckh_out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (predict_result(in_data, res)) awaited_results.push_back(res);
      end
      if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_data <= request_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off.
  int  recv_stall = 0;
  int  long_hold = 0;
  bit  held_once = 0;
  bit  recv_calm = 0;
  always @(posedge clk) begin
    ckh_out_t want;
    bit rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.kick_count !== want.kick_count) begin
            $error("kick_count: expected %0d, got %0d", want.kick_count, out_data.kick_count);
            mismatches++;
          end
          if (out_data.entry_valid !== want.entry_valid) begin
            $error("entry_valid: expected %0d, got %0d", want.entry_valid,
                   out_data.entry_valid);
            mismatches++;
          end
          if (out_data.entry_item !== want.entry_item) begin
            $error("entry_item: expected %0d, got %0d", want.entry_item, out_data.entry_item);
            mismatches++;
          end
          if (out_data.entry_choice !== want.entry_choice) begin
            $error("entry_choice: expected %0d, got %0d", want.entry_choice,
                   out_data.entry_choice);
            mismatches++;
          end
          if (out_data.stash_fill !== want.stash_fill) begin
            $error("stash_fill: expected %0d, got %0d", want.stash_fill, out_data.stash_fill);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      if (!held_once && results_seen >= 300) begin
        held_once = 1;
        long_hold = 600;
      end
      if (long_hold > 0) begin
        long_hold--;
        rdy = 0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rdy = 0;
      end else begin
        rdy = 1;
        recv_stall = draw_gap(recv_calm);
      end
      out_ready <= rdy;
    end
  end

  // Watchdog on cycles without any accepted beat.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("** cuckoo_hash_insert_stash: FAILED **");
      $finish;
    end
  end

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BIN_COUNT) bin_count_m = val;
    else if (idx == REG_MAX_KICKS) max_kicks_m = val;
  endtask

  task automatic drain();
    while (request_queue.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    foreach (occupied_m[i]) occupied_m[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, the unknown request, extreme hashes, a bouncing chain.
    request_queue.push_back(make_request(REQ_READ_BIN, 0, 0, 0, 0, 11'd0, 0));
    request_queue.push_back(make_request(REQ_READ_BIN, 0, 0, 0, 0, 11'd2047, 0));
    request_queue.push_back(make_request(REQ_READ_STASH, 0, 0, 0, 0, 0, 4'd0));
    request_queue.push_back(make_request(REQ_READ_STASH, 0, 0, 0, 0, 0, 4'd15));
    request_queue.push_back(make_request(REQ_UNKNOWN, 10'h3FF, '1, '1, '1, 11'h7FF, 4'hF));
    request_queue.push_back(make_request(REQ_INSERT, 10'd0, '0, '0, '0, 0, 0));
    request_queue.push_back(make_request(REQ_INSERT, 10'd1023, '1, '1, '1, 0, 0));
    request_queue.push_back(make_request(REQ_READ_BIN, 0, 0, 0, 0, 11'd0, 0));
    // Both items hash only to bin 0, so the chain runs to the kick limit.
    request_queue.push_back(make_request(REQ_INSERT, 10'd5, '0, 64'd1229, 64'd2458, 0, 0));
    request_queue.push_back(make_request(REQ_READ_STASH, 0, 0, 0, 0, 0, 4'd0));
    request_queue.push_back(make_request(REQ_READ_BIN, 0, 0, 0, 0, 11'd0, 0));
    // Repeated insert of one item with new hashes.
    request_queue.push_back(make_request(REQ_INSERT, 10'd1023, 64'd7, 64'd8, 64'd9, 0, 0));
    request_queue.push_back(make_request(REQ_READ_BIN, 0, 0, 0, 0, 11'd7, 0));
    request_queue.push_back(make_request(REQ_READ_BIN, 0, 0, 0, 0,
                                         11'(64'hFFFF_FFFF_FFFF_FFFF % 1229), 0));
    repeat (6) request_queue.push_back(rand_request(60, 1229));
    drain();

    // Bin count zero behaves as one bin, no kicks allowed: the stash fills, then drops.
    write_reg(REG_BIN_COUNT, 12'd0);
    write_reg(REG_MAX_KICKS, 12'd0);
    write_reg(REG_UNUSED, 12'hFFF);
    repeat (20) request_queue.push_back(rand_request(100, 1));
    for (int s = 0; s < STASH_SLOTS; s++)
      request_queue.push_back(make_request(REQ_READ_STASH, 0, 0, 0, 0, 0, 4'(s)));
    drain();

    // Bin count above the depth saturates; the largest kick limit.
    write_reg(REG_BIN_COUNT, 12'hFFF);
    write_reg(REG_MAX_KICKS, 12'hFFF);
    repeat (300) request_queue.push_back(rand_request(55, 2048));
    drain();

    // Small tables with short kick limits give eviction chains and drops.
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_BIN_COUNT, 12'($urandom_range(2, 16)));
      write_reg(REG_MAX_KICKS, 12'($urandom_range(1, 12)));
      repeat (190) request_queue.push_back(rand_request(65, 20));
      drain();
    end

    if (mismatches == 0)
      $display("** cuckoo_hash_insert_stash: PASSED **");
    else
      $display("** cuckoo_hash_insert_stash: FAILED **");
    $finish;
  end

endmodule
